[rtl/iiss_pkg.sv]
// Shared widths, register indexes and the line buffer entry type for the
// integral image block. No dependencies.
`default_nettype none

package iiss_pkg;

    localparam int PIXEL_W  = 8;
    localparam int SUM_W    = 28;
    localparam int SQ_W     = 36;
    localparam int ROW_W    = 18;
    localparam int ROWSQ_W  = 27;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

    // one line buffer entry: sums of the row above at one column
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
    } t_line;

endpackage

`default_nettype wire

[rtl/integral_image_with_square_sums.sv]
// Streaming integral image and squared integral image, top level.
// Depends on iiss_pkg.
//
// Usage:
//   Pixels enter in raster order on i_pixel, one transfer when i_in_valid is
//   high and o_in_stall is low. Each pixel gives one result on o_area_sum,
//   o_area_square_sum and o_frame_end (high on the window's last pixel), one
//   transfer when o_out_valid is high and i_out_stall is low.
//   Window size is set by a write on i_cfg_we / i_cfg_index / i_cfg_data
//   (index 0 frame width, index 1 frame height), only while the block is
//   idle. A zero size acts as 1, a size above the maximum as the maximum.
//   The pipeline has two register stages, the first stage and the result
//   register. Throughput is one pixel per cycle while the receiver does not
//   stall; the line buffer is a single-port-write, single-port-read memory
//   read when a pixel is taken and written when it leaves the first stage,
//   with a bypass for a one-pixel-wide window.
//   Reset sets both sizes to 1024 (clamped to the maximum), clears the row
//   and column position and the running row totals. The line buffer is not
//   cleared; the first row of each frame never uses its contents.
//   While the receiver stalls, the result register holds and one more pixel
//   can sit in the first stage; after that o_in_stall rises.
`default_nettype none

module integral_image_with_square_sums
    import iiss_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [PIXEL_W-1:0]   i_pixel,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [SUM_W-1:0]          o_area_sum,
    output logic [SQ_W-1:0]           o_area_square_sum,
    output logic                      o_frame_end
);

    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    function automatic int f_last(input logic [CFG_W-1:0] v, input int maxv);
        int r;
        if (v == '0) begin
            r = 0;
        end else if (int'(v) > maxv) begin
            r = maxv - 1;
        end else begin
            r = int'(v) - 1;
        end
        return r;
    endfunction

    // configuration: last column and last row indexes
    logic [CW-1:0] r_w_last;
    logic [RW-1:0] r_h_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(f_last(CFG_SIZE_RESET, MAX_WIDTH));
            r_h_last <= RW'(f_last(CFG_SIZE_RESET, MAX_HEIGHT));
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_w_last <= CW'(f_last(i_cfg_data, MAX_WIDTH));
                CFG_FRAME_HEIGHT: r_h_last <= RW'(f_last(i_cfg_data, MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    // handshake
    logic r_a_valid;
    logic r_o_valid;
    logic advance;
    logic in_accept;

    assign advance    = !r_o_valid || !i_out_stall;
    assign o_in_stall = r_a_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // position and running row totals
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [ROW_W-1:0]   r_row_total;
    logic [ROWSQ_W-1:0] r_row_sq_total;
    logic [ROW_W-1:0]   n_row_total;
    logic [ROWSQ_W-1:0] n_row_sq_total;
    logic [2*PIXEL_W-1:0] px_sq;
    logic last_col;
    logic last_row;

    assign last_col       = r_col >= r_w_last;
    assign last_row       = r_row >= r_h_last;
    assign px_sq          = (2*PIXEL_W)'(i_pixel) * (2*PIXEL_W)'(i_pixel);
    assign n_row_total    = r_row_total + ROW_W'(i_pixel);
    assign n_row_sq_total = r_row_sq_total + ROWSQ_W'(px_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col          <= '0;
            r_row          <= '0;
            r_row_total    <= '0;
            r_row_sq_total <= '0;
        end else if (in_accept) begin
            if (last_col) begin
                r_col          <= '0;
                r_row          <= last_row ? '0 : r_row + RW'(1);
                r_row_total    <= '0;
                r_row_sq_total <= '0;
            end else begin
                r_col          <= r_col + CW'(1);
                r_row_total    <= n_row_total;
                r_row_sq_total <= n_row_sq_total;
            end
        end
    end

    // line buffer
    t_line mem [MAX_WIDTH];
    t_line r_rd;
    t_line r_fwd_data;
    t_line wr_data;
    logic  wr_en;
    logic  r_fwd;

    // first stage
    logic [CW-1:0]      r_a_col;
    logic [ROW_W-1:0]   r_a_row_total;
    logic [ROWSQ_W-1:0] r_a_row_sq_total;
    logic               r_a_first_row;
    logic               r_a_end;

    t_line up;

    always_comb begin
        if (r_a_first_row) begin
            up = '0;
        end else if (r_fwd) begin
            up = r_fwd_data;
        end else begin
            up = r_rd;
        end
        wr_data.sum = up.sum + SUM_W'(r_a_row_total);
        wr_data.sq  = up.sq + SQ_W'(r_a_row_sq_total);
    end

    assign wr_en = r_a_valid && advance;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_a_col] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd <= mem[r_col];
        end
    end

    // same column written and read in one cycle only on a one-pixel-wide row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (in_accept) begin
            r_fwd <= wr_en && (r_a_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_fwd_data       <= wr_data;
            r_a_col          <= r_col;
            r_a_row_total    <= n_row_total;
            r_a_row_sq_total <= n_row_sq_total;
            r_a_first_row    <= (r_row == '0);
            r_a_end          <= last_col && last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (advance) begin
            r_a_valid <= 1'b0;
        end
    end

    // result register
    logic [SUM_W-1:0] r_o_sum;
    logic [SQ_W-1:0]  r_o_sq;
    logic             r_o_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_o_sum <= wr_data.sum;
            r_o_sq  <= wr_data.sq;
            r_o_end <= r_a_end;
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_area_sum        = r_o_sum;
    assign o_area_square_sum = r_o_sq;
    assign o_frame_end       = r_o_end;

    // checks
    a_fwd_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_fwd |-> r_w_last == '0)
        else $error("line buffer bypass used on a row wider than one pixel");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_a_valid && r_o_valid && i_out_stall)
        else $error("input stalled without a full pipeline");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && last_col && last_row |=> r_col == '0 && r_row == '0)
        else $error("position not cleared after the last pixel of a frame");

    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && advance |=> r_o_valid)
        else $error("result lost between first stage and result register");

endmodule

`default_nettype wire

[bench/integral_image_with_square_sums_tb.sv]
// Self-checking bench for integral_image_with_square_sums: a queue-fed pixel
// driver, a running-sum predictor and a result checker. Depends on iiss_pkg.
`timescale 1ns / 1ps

module integral_image_with_square_sums_tb
    import iiss_pkg::*;
();

    localparam int MAX_W      = 1024;
    localparam int MAX_H      = 1024;
    localparam int RAND_ITEMS = 450;
    localparam int LIMIT      = 400000;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
        logic             frame_end;
    } t_area_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic [PIXEL_W-1:0]   i_pixel = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [SUM_W-1:0]     o_area_sum;
    logic [SQ_W-1:0]      o_area_square_sum;
    logic                 o_frame_end;

    integral_image_with_square_sums #(
        .MAX_WIDTH (MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pixel          (i_pixel),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_area_sum       (o_area_sum),
        .o_area_square_sum(o_area_square_sum),
        .o_frame_end      (o_frame_end)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [PIXEL_W-1:0] pixels_pending[$];
    t_area_result       sums_due[$];
    int                 fail_count = 0;
    int unsigned        cycle_count = 0;
    bit                 calm = 1'b0;

    // predictor state
    logic [SUM_W-1:0]   line_sum[0:MAX_W-1];
    logic [SQ_W-1:0]    line_sq[0:MAX_W-1];
    bit                 line_written[0:MAX_W-1];
    logic [ROW_W-1:0]   run_row_sum;
    logic [ROWSQ_W-1:0] run_row_sq;
    int unsigned        pos_col;
    int unsigned        pos_row;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return 32'(v);
    endfunction

    task automatic predict_pixel(input logic [PIXEL_W-1:0] px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        bit           last_c;
        bit           last_r;
        logic [SUM_W-1:0] up;
        logic [SQ_W-1:0]  up_sq;
        t_area_result r;
        w = eff_size(width_reg, MAX_W);
        h = eff_size(height_reg, MAX_H);
        c = pos_col;
        last_c = (c >= w - 1);
        last_r = (pos_row >= h - 1);
        if (c >= MAX_W)
            c = MAX_W - 1;
        run_row_sum = run_row_sum + ROW_W'(px);
        run_row_sq  = run_row_sq + ROWSQ_W'(px) * ROWSQ_W'(px);
        up = '0;
        up_sq = '0;
        if (pos_row != 0) begin
            up = line_sum[c];
            up_sq = line_sq[c];
        end
        r.sum = up + SUM_W'(run_row_sum);
        r.sq = up_sq + SQ_W'(run_row_sq);
        r.frame_end = last_c && last_r;
        line_sum[c] = r.sum;
        line_sq[c] = r.sq;
        line_written[c] = 1'b1;
        sums_due.push_back(r);
        if (last_c) begin
            pos_col = 0;
            run_row_sum = '0;
            run_row_sq = '0;
            pos_row = last_r ? 0 : pos_row + 1;
        end else begin
            pos_col = c + 1;
        end
    endtask

    // checker first, then register copies, then prediction of this edge's transfer
    always @(posedge i_clk) begin
        t_area_result e;
        if (!i_rst_n) begin
            width_reg = CFG_SIZE_RESET;
            height_reg = CFG_SIZE_RESET;
            run_row_sum = '0;
            run_row_sq = '0;
            pos_col = 0;
            pos_row = 0;
            for (int k = 0; k < MAX_W; k++)
                line_written[k] = 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (sums_due.size() == 0) begin
                    $display("%0t unexpected result: expected none actual sum %0d sq %0d end %0b",
                             $time, o_area_sum, o_area_square_sum, o_frame_end);
                    fail_count++;
                end else begin
                    e = sums_due.pop_front();
                    if (o_area_sum !== e.sum) begin
                        $display("%0t area_sum: expected %0d actual %0d",
                                 $time, e.sum, o_area_sum);
                        fail_count++;
                    end
                    if (o_area_square_sum !== e.sq) begin
                        $display("%0t area_square_sum: expected %0d actual %0d",
                                 $time, e.sq, o_area_square_sum);
                        fail_count++;
                    end
                    if (o_frame_end !== e.frame_end) begin
                        $display("%0t frame_end: expected %0b actual %0b",
                                 $time, e.frame_end, o_frame_end);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FRAME_WIDTH)
                    width_reg = i_cfg_data;
                else if (i_cfg_index == CFG_FRAME_HEIGHT)
                    height_reg = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall)
                predict_pixel(i_pixel);
        end
    end

    // pixel driver: valid held until the transfer completes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pixels_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 12)) begin
                i_in_valid <= 1'b1;
                i_pixel <= pixels_pending.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= !calm && ($urandom_range(0, 99) < 12);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("integral_image_with_square_sums: mismatch");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // block is idle once nothing is queued, in flight or outstanding
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pixels_pending.size() != 0 || i_in_valid || sums_due.size() != 0);
    endtask

    task automatic send_pixels(input logic [PIXEL_W-1:0] px[$]);
        foreach (px[k])
            pixels_pending.push_back(px[k]);
        wait_drained();
    endtask

    function automatic logic [PIXEL_W-1:0] rand_pixel();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return PIXEL_W'($urandom_range(0, 255));
    endfunction

    // a wider row must not read line entries that were never written
    function automatic bit width_safe(input logic [CFG_W-1:0] v);
        int unsigned w;
        w = eff_size(v, MAX_W);
        if (pos_row == 0)
            return 1'b1;
        for (int unsigned c = pos_col; c < w; c++)
            if (!line_written[c])
                return 1'b0;
        return 1'b1;
    endfunction

    initial begin
        int unsigned      sent;
        int unsigned      phase;
        int unsigned      r;
        int unsigned      n;
        int unsigned      w;
        int unsigned      h;
        int unsigned      to_end;
        logic [CFG_W-1:0] new_w;
        logic [CFG_W-1:0] new_h;
        logic [PIXEL_W-1:0] batch[$];

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset sizes, top row only
        send_pixels('{8'd255, 8'd255, 8'd0, 8'd128});
        // zero sizes act as one: every pixel ends the frame, mid-row
        write_reg(CFG_FRAME_WIDTH, 11'd0);
        write_reg(CFG_FRAME_HEIGHT, 11'd0);
        send_pixels('{8'd255, 8'd1});
        // one-pixel-wide window over several rows
        write_reg(CFG_FRAME_WIDTH, 11'd1);
        write_reg(CFG_FRAME_HEIGHT, 11'd3);
        send_pixels('{8'd255, 8'd255, 8'd255});
        // oversized values saturate
        write_reg(CFG_FRAME_WIDTH, 11'd2047);
        write_reg(CFG_FRAME_HEIGHT, 11'd2047);
        send_pixels('{8'd255, 8'd0, 8'd77});
        // width shrunk mid-row: current column ends the row
        write_reg(CFG_FRAME_WIDTH, 11'd3);
        write_reg(CFG_FRAME_HEIGHT, 11'd2);
        send_pixels('{8'd200, 8'd255, 8'd255, 8'd255});
        // height shrunk mid-frame: current row ends the frame
        write_reg(CFG_FRAME_WIDTH, 11'd2);
        write_reg(CFG_FRAME_HEIGHT, 11'd4);
        send_pixels('{8'd9, 8'd255, 8'd0, 8'd254});
        write_reg(CFG_FRAME_HEIGHT, 11'd1);
        send_pixels('{8'd255, 8'd3});

        sent = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 50)       new_w = CFG_W'($urandom_range(1, 8));
            else if (r < 80)  new_w = CFG_W'($urandom_range(9, 40));
            else if (r < 88)  new_w = CFG_W'($urandom_range(41, 1023));
            else if (r < 94)  new_w = 11'd1024;
            else if (r < 97)  new_w = 11'd0;
            else              new_w = CFG_W'($urandom_range(1025, 2047));
            r = $urandom_range(0, 99);
            if (r < 60)       new_h = CFG_W'($urandom_range(1, 4));
            else if (r < 85)  new_h = CFG_W'($urandom_range(5, 12));
            else if (r < 92)  new_h = CFG_W'($urandom_range(13, 1024));
            else if (r < 96)  new_h = 11'd0;
            else              new_h = CFG_W'($urandom_range(1025, 2047));
            if (!width_safe(new_w))
                new_w = width_reg;
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_FRAME_WIDTH, new_w);
                write_reg(CFG_FRAME_HEIGHT, new_h);
            end else begin
                write_reg(CFG_FRAME_HEIGHT, new_h);
                write_reg(CFG_FRAME_WIDTH, new_w);
            end

            w = eff_size(width_reg, MAX_W);
            h = eff_size(height_reg, MAX_H);
            to_end = ((pos_col >= w - 1) ? 1 : w - pos_col)
                   + ((pos_row >= h - 1) ? 0 : (h - 1 - pos_row) * w);
            // mostly finish the frame in progress, sometimes a stray burst
            if (to_end <= 150 && $urandom_range(0, 99) < 80) begin
                n = to_end;
                if (w * h <= 60 && $urandom_range(0, 1))
                    n += w * h;
            end else begin
                n = $urandom_range(1, 40);
            end

            calm = (phase % 6 == 3);
            // calm bursts are long enough to run back to back for a while
            if (calm && n < 64)
                n += 64;
            batch.delete();
            repeat (n)
                batch.push_back(rand_pixel());
            send_pixels(batch);
            calm = 1'b0;
            sent += n;
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sums_due.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("integral_image_with_square_sums: match");
        else
            $display("integral_image_with_square_sums: mismatch");
        $finish;
    end

endmodule

[integral_image_with_square_sums.f]
rtl/iiss_pkg.sv
rtl/integral_image_with_square_sums.sv
bench/integral_image_with_square_sums_tb.sv
